/* hw/rtl/spl_pkg.sv */
// ----------------------------------------------------------------------------
// spl_pkg
// Shared constants, types and tables for the cubic spline erf pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package spl_pkg;

  localparam int IN_FRAC_BITS_DEF  = 16;
  localparam int OUT_FRAC_BITS_DEF = 16;

  localparam int FRAC   = 24;
  localparam int NSEG   = 10;
  localparam int XQ_W   = 28;
  localparam int D_W    = 25;
  localparam int ACC_W  = 28;
  localparam int PROD_W = ACC_W + D_W;
  localparam int SEG_W  = 4;

  typedef logic [SEG_W-1:0]        seg_t;
  typedef logic signed [XQ_W-1:0]  xq_t;
  typedef logic signed [D_W-1:0]   dlt_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic sat_lo;
    logic sat_hi;
    logic neg;
  } ctl_t;

  localparam int KNOT_TBL [NSEG+1] = '{
    -48653926, -38587597, -28521267, -18454938, -8388608,
    1677722, 11744051, 21810381, 31876710, 41943040, 52009370
  };

  localparam int COEF_TBL [NSEG][4] = '{
    '{    3205,     5769,     3436, -16776526},
    '{   66441,   125363,    82115, -16758037},
    '{  733202,  1445127,  1024410, -16505265},
    '{ 2791588,  6469985,  5773477, -14767391},
    '{ 1118384,  8483076, 14745314,  -8732539},
    '{-5933991, -2198107, 18516294,   1886815},
    '{-3859518, -9145239, 11710287,  11371617},
    '{ 2613658, -4440654,  3558750,  15670053},
    '{ 2081444,  -694055,   477925,  16656259},
    '{  357565,   -50438,    31229,  16770388}
  };

  function automatic xq_t get_knot(input seg_t idx);
    xq_t k;
    k = '0;
    if (idx <= SEG_W'(NSEG)) begin
      k = XQ_W'(KNOT_TBL[idx]);
    end
    return k;
  endfunction

  function automatic acc_t get_coef(input seg_t seg, input logic [1:0] idx);
    acc_t c;
    c = '0;
    if (seg < SEG_W'(NSEG)) begin
      c = ACC_W'(COEF_TBL[seg][idx]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/spline_erf_approx_core.sv */
// ----------------------------------------------------------------------------
// spline_erf_approx_core
// Piecewise cubic spline approximation of erf(x), Q4.IN to Q2.OUT.
// Throughput: one request per cycle while out_stall is low; eleven register stages, each with its
// own valid bit, so bubbles close up behind a stalled output.
// Reset: synchronous, clears all valid bits and sets mirror_r to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module spline_erf_approx_core import spl_pkg::*; #(
  parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic                            cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [IN_FRAC_BITS+3:0]  in_sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [OUT_FRAC_BITS+1:0]      out_erf_value
);

  logic mirror_r;

  logic seg_ready;
  logic seg_valid;
  dlt_t seg_d;
  seg_t seg_idx;
  ctl_t seg_ctl;

  logic hor_ready;
  logic hor_valid;
  acc_t hor_acc;
  ctl_t hor_ctl;

  logic fin_ready;

  assign cfg_ready = 1'b1;
  assign in_stall  = !seg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mirror_r <= cfg_data;
    end
  end

  spl_seg #(
    .IN_FRAC_BITS(IN_FRAC_BITS)
  ) u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .mirror   (mirror_r),
    .up_valid (in_valid),
    .up_sample(in_sample),
    .up_ready (seg_ready),
    .dn_valid (seg_valid),
    .dn_d     (seg_d),
    .dn_seg   (seg_idx),
    .dn_ctl   (seg_ctl),
    .dn_ready (hor_ready)
  );

  spl_horner u_horner (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(seg_valid),
    .up_d    (seg_d),
    .up_seg  (seg_idx),
    .up_ctl  (seg_ctl),
    .up_ready(hor_ready),
    .dn_valid(hor_valid),
    .dn_acc  (hor_acc),
    .dn_ctl  (hor_ctl),
    .dn_ready(fin_ready)
  );

  spl_out #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (hor_valid),
    .up_acc       (hor_acc),
    .up_ctl       (hor_ctl),
    .up_ready     (fin_ready),
    .out_valid    (out_valid),
    .out_erf_value(out_erf_value),
    .out_stall    (out_stall)
  );

endmodule

`default_nettype wire

/* hw/rtl/spl_seg.sv */
// ----------------------------------------------------------------------------
// spl_seg
// Front end: scale the sample to Q.24, fold for mirror mode, pick the segment
// and form the offset from its left knot. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_seg import spl_pkg::*; #(
  parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           mirror,
  input  wire logic                           up_valid,
  input  wire logic signed [IN_FRAC_BITS+3:0] up_sample,
  output logic                                up_ready,
  output logic                                dn_valid,
  output dlt_t                                dn_d,
  output seg_t                                dn_seg,
  output ctl_t                                dn_ctl,
  input  wire logic                           dn_ready
);

  localparam int SH = FRAC - IN_FRAC_BITS;

  logic en1, en2, en3;
  logic vld1_r, vld2_r, vld3_r;
  xq_t  v1_r, v2_r;
  logic neg1_r;
  ctl_t ctl2_r, ctl3_r;
  seg_t seg2_r, seg3_r;
  dlt_t d3_r;

  xq_t  xq;
  xq_t  v1_nxt;
  logic neg1_nxt;
  ctl_t ctl2_nxt;
  seg_t seg2_nxt;
  xq_t  diff;
  dlt_t d3_nxt;

  assign en3      = !vld3_r || dn_ready;
  assign en2      = !vld2_r || en3;
  assign en1      = !vld1_r || en2;
  assign up_ready = en1;

  // fold to the negative half in mirror mode
  always_comb begin
    xq       = XQ_W'(up_sample) <<< SH;
    neg1_nxt = mirror && !xq[XQ_W-1];
    v1_nxt   = neg1_nxt ? -xq : xq;
  end

  always_comb begin
    ctl2_nxt.sat_lo = (v1_r <= get_knot(SEG_W'(0)));
    ctl2_nxt.sat_hi = (v1_r >= get_knot(SEG_W'(NSEG)));
    ctl2_nxt.neg    = neg1_r;
    seg2_nxt        = '0;
    for (int i = 1; i < NSEG; i++) begin
      if (v1_r >= get_knot(SEG_W'(i))) begin
        seg2_nxt = SEG_W'(i);
      end
    end
  end

  always_comb begin
    diff   = v2_r - get_knot(seg2_r);
    d3_nxt = diff[D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      if (en1) vld1_r <= up_valid;
      if (en2) vld2_r <= vld1_r;
      if (en3) vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      v1_r   <= v1_nxt;
      neg1_r <= neg1_nxt;
    end
    if (en2 && vld1_r) begin
      v2_r   <= v1_r;
      ctl2_r <= ctl2_nxt;
      seg2_r <= seg2_nxt;
    end
    if (en3 && vld2_r) begin
      d3_r   <= d3_nxt;
      ctl3_r <= ctl2_r;
      seg3_r <= seg2_r;
    end
  end

  assign dn_valid = vld3_r;
  assign dn_d     = d3_r;
  assign dn_seg   = seg3_r;
  assign dn_ctl   = ctl3_r;

  a_sat_excl: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> !(ctl2_r.sat_lo && ctl2_r.sat_hi))
    else $error("both saturation flags set");

  a_neg_no_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (vld2_r && ctl2_r.neg) |-> !ctl2_r.sat_hi)
    else $error("folded sample flagged above top knot");

  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld3_r |-> (seg3_r <= SEG_W'(NSEG - 1)))
    else $error("segment index out of range");

endmodule

`default_nettype wire

/* hw/rtl/spl_horner.sv */
// ----------------------------------------------------------------------------
// spl_horner
// Horner evaluation of the segment cubic: three rounds, each a multiply stage
// followed by a round-and-add stage. Six register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_horner import spl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic up_valid,
  input  wire dlt_t up_d,
  input  wire seg_t up_seg,
  input  wire ctl_t up_ctl,
  output logic      up_ready,
  output logic      dn_valid,
  output acc_t      dn_acc,
  output ctl_t      dn_ctl,
  input  wire logic dn_ready
);

  localparam int NRND = 3;
  localparam int NSTG = 2 * NRND;
  localparam prod_t HALF_LSB = PROD_W'(1) <<< (FRAC - 1);

  logic  vld_r [NSTG];
  dlt_t  d_r   [NSTG];
  seg_t  seg_r [NSTG];
  ctl_t  ctl_r [NSTG];
  prod_t p_r   [NRND];
  acc_t  acc_r [NRND];

  logic  en    [NSTG];
  logic  vin   [NSTG];
  dlt_t  din   [NSTG];
  seg_t  sin   [NSTG];
  ctl_t  cin   [NSTG];
  prod_t p_nxt   [NRND];
  acc_t  acc_nxt [NRND];
  acc_t  mul_a   [NRND];
  prod_t sum     [NRND];

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || dn_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
    vin[0] = up_valid;
    din[0] = up_d;
    sin[0] = up_seg;
    cin[0] = up_ctl;
    for (int i = 1; i < NSTG; i++) begin
      vin[i] = vld_r[i-1];
      din[i] = d_r[i-1];
      sin[i] = seg_r[i-1];
      cin[i] = ctl_r[i-1];
    end
  end

  // multiply stages
  always_comb begin
    mul_a[0] = get_coef(up_seg, 2'd0);
    for (int k = 1; k < NRND; k++) begin
      mul_a[k] = acc_r[k-1];
    end
    for (int k = 0; k < NRND; k++) begin
      p_nxt[k] = PROD_W'(mul_a[k]) * PROD_W'(din[2*k]);
    end
  end

  // round half up to Q.24 and add the next coefficient in one sum
  always_comb begin
    for (int k = 0; k < NRND; k++) begin
      sum[k] = p_r[k] + (PROD_W'(get_coef(seg_r[2*k], 2'(k + 1))) <<< FRAC) + HALF_LSB;
      acc_nxt[k] = sum[k][FRAC +: ACC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (en[i]) vld_r[i] <= vin[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (en[i] && vin[i]) begin
        d_r[i]   <= din[i];
        seg_r[i] <= sin[i];
        ctl_r[i] <= cin[i];
      end
    end
    for (int k = 0; k < NRND; k++) begin
      if (en[2*k] && vin[2*k]) p_r[k] <= p_nxt[k];
      if (en[2*k+1] && vin[2*k+1]) acc_r[k] <= acc_nxt[k];
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld_r[NSTG-1];
  assign dn_acc   = acc_r[NRND-1];
  assign dn_ctl   = ctl_r[NSTG-1];

endmodule

`default_nettype wire

/* hw/rtl/spl_out.sv */
// ----------------------------------------------------------------------------
// spl_out
// Back end: apply saturation and mirror sign in Q.24, round to the output
// format, clamp to +/-1 and hold the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_out import spl_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             up_valid,
  input  wire acc_t                             up_acc,
  input  wire ctl_t                             up_ctl,
  output logic                                  up_ready,
  output logic                                  out_valid,
  output logic signed [OUT_FRAC_BITS+1:0]       out_erf_value,
  input  wire logic                             out_stall
);

  localparam int OUT_W = OUT_FRAC_BITS + 2;
  localparam int OS    = FRAC - OUT_FRAC_BITS;
  localparam acc_t ONE    = ACC_W'(1) <<< FRAC;
  localparam acc_t HALF_O = (ACC_W'(1) << OS) >> 1;
  localparam acc_t LIM    = ACC_W'(1) <<< OUT_FRAC_BITS;
  localparam logic signed [OUT_W-1:0] LIM_O = OUT_W'(1) <<< OUT_FRAC_BITS;

  logic en1, en2;
  logic vld1_r, out_valid_r;
  acc_t r1_r;
  logic signed [OUT_W-1:0] erf_r;

  acc_t sel;
  acc_t r1_nxt;
  acc_t rnd;
  acc_t clp;
  logic signed [OUT_W-1:0] erf_nxt;

  assign en2      = !out_valid_r || !out_stall;
  assign en1      = !vld1_r || en2;
  assign up_ready = en1;

  always_comb begin
    if (up_ctl.sat_lo) begin
      sel = -ONE;
    end else if (up_ctl.sat_hi) begin
      sel = ONE;
    end else begin
      sel = up_acc;
    end
    r1_nxt = up_ctl.neg ? -sel : sel;
  end

  always_comb begin
    rnd = (r1_r + HALF_O) >>> OS;
    if (rnd > LIM) begin
      clp = LIM;
    end else if (rnd < -LIM) begin
      clp = -LIM;
    end else begin
      clp = rnd;
    end
    erf_nxt = clp[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) vld1_r <= up_valid;
      if (en2) out_valid_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) r1_r <= r1_nxt;
    if (en2 && vld1_r) erf_r <= erf_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_erf_value = erf_r;

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (erf_r <= LIM_O && erf_r >= -LIM_O))
    else $error("result outside +/-1");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

`default_nettype wire

/* tb/spline_erf_approx_core_test.sv */
// ----------------------------------------------------------------------------
// spline_erf_approx_core_test
// Streams Q4.16 samples through the spline erf core in both the full and
// the mirrored mode. Each request is predicted in Q.24 fixed point with
// Horner evaluation per segment, and every result is compared in order.
// Both handshake sides idle and stall at random, with one steady phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spline_erf_approx_core_test;
  import spl_pkg::*;

  localparam int IN_W    = IN_FRAC_BITS_DEF + 4;
  localparam int OUT_W   = OUT_FRAC_BITS_DEF + 2;
  localparam int IN_SH   = FRAC - IN_FRAC_BITS_DEF;
  localparam int OUT_SH  = FRAC - OUT_FRAC_BITS_DEF;
  localparam int SEGS    = 10;
  localparam longint ONE = longint'(1) <<< FRAC;

  localparam int KNOT_TENTHS [SEGS+1] = '{-29, -23, -17, -11, -5, 1, 7, 13, 19, 25, 31};

  localparam longint SPLINE_COEF [SEGS][4] = '{
    '{    3205,     5769,     3436, -16776526},
    '{   66441,   125363,    82115, -16758037},
    '{  733202,  1445127,  1024410, -16505265},
    '{ 2791588,  6469985,  5773477, -14767391},
    '{ 1118384,  8483076, 14745314,  -8732539},
    '{-5933991, -2198107, 18516294,   1886815},
    '{-3859518, -9145239, 11710287,  11371617},
    '{ 2613658, -4440654,  3558750,  15670053},
    '{ 2081444,  -694055,   477925,  16656259},
    '{  357565,   -50438,    31229,  16770388}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IN_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_erf_value;
  int idle_pct = 32;

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint knot_at(input int idx);
    longint t;
    t = longint'(KNOT_TENTHS[idx]) * ONE;
    if (t >= 0) return (t + 5) / 10;
    return -((-t + 5) / 10);
  endfunction

  function automatic longint horner_seg(input int seg, input longint xq);
    longint d;
    longint acc;
    d = xq - knot_at(seg);
    acc = SPLINE_COEF[seg][0];
    acc = rnd_shift(acc * d, FRAC) + SPLINE_COEF[seg][1];
    acc = rnd_shift(acc * d, FRAC) + SPLINE_COEF[seg][2];
    acc = rnd_shift(acc * d, FRAC) + SPLINE_COEF[seg][3];
    return acc;
  endfunction

  function automatic longint full_curve(input longint xq);
    if (xq <= knot_at(0)) return -ONE;
    for (int s = 0; s < SEGS; s++) begin
      if (xq < knot_at(s + 1)) return horner_seg(s, xq);
    end
    return ONE;
  endfunction

  function automatic longint half_curve(input longint mq);
    if (mq <= knot_at(0)) return -ONE;
    for (int s = 0; s < 4; s++) begin
      if (mq < knot_at(s + 1)) return horner_seg(s, mq);
    end
    return horner_seg(4, mq);
  endfunction

  function automatic logic signed [OUT_W-1:0] predict_erf(input logic signed [IN_W-1:0] x,
                                                          input bit mirror);
    longint xq;
    longint r;
    longint lim;
    xq = longint'(x) <<< IN_SH;
    if (mirror) begin
      r = (xq >= 0) ? -half_curve(-xq) : half_curve(xq);
    end else begin
      r = full_curve(xq);
    end
    r = rnd_shift(r, OUT_SH);
    lim = longint'(1) <<< OUT_FRAC_BITS_DEF;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[OUT_W-1:0];
  endfunction

  class erf_check;
    bit mirror;
    int fails;
    logic signed [OUT_W-1:0] erf_due[$];

    function void note_sample(logic signed [IN_W-1:0] x);
      erf_due.push_back(predict_erf(x, mirror));
    endfunction

    function void check_erf(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      if (erf_due.size() == 0) begin
        $error("erf_value: expected none, actual %0d", got);
        fails++;
        return;
      end
      want = erf_due.pop_front();
      if (got !== want) begin
        $error("erf_value: expected %0d, actual %0d", want, got);
        fails++;
      end
    endfunction
  endclass

  erf_check book = new();

  spline_erf_approx_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_erf_value (out_erf_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_erf(out_erf_value);
    end
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic send_request(input logic signed [IN_W-1:0] x);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (in_stall);
    book.note_sample(x);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (book.erf_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.mirror = m;
  endtask

  task automatic run_directed;
    longint f;
    for (int k = 0; k <= SEGS; k++) begin
      f = knot_at(k) >>> IN_SH;
      send_request(f[IN_W-1:0]);
      send_request(f[IN_W-1:0] + 1'b1);
    end
    send_request({1'b0, {(IN_W-1){1'b1}}});
    send_request({1'b1, {(IN_W-1){1'b0}}});
    send_request('0);
  endtask

  function automatic logic signed [IN_W-1:0] pick_sample();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 15) return IN_W'($urandom);
    if (sel < 35) begin
      v = int'(knot_at($urandom_range(SEGS)) >>> IN_SH) + int'($urandom_range(8)) - 4;
      if ($urandom_range(1)) v = -v;
      return v[IN_W-1:0];
    end
    v = int'($urandom_range(410000)) - 200000;
    return v[IN_W-1:0];
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_request(pick_sample());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(1'b0);
    run_directed();
    write_mode(1'b1);
    run_directed();
    write_mode(1'b0);
    run_random(165);
    write_mode(1'b1);
    run_random(165);
    idle_pct = 0;
    write_mode(1'b0);
    run_random(160);
    idle_pct = 32;
    write_mode(1'b1);
    run_random(165);
    drain();
    repeat (20) @(posedge clk);
    if (book.fails == 0 && book.erf_due.size() == 0) begin
      $display("spline_erf_approx_core test passed");
    end else begin
      $display("spline_erf_approx_core test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("spline_erf_approx_core test failed");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/spl_pkg.sv
hw/rtl/spl_seg.sv
hw/rtl/spl_horner.sv
hw/rtl/spl_out.sv
hw/rtl/spline_erf_approx_core.sv
tb/spline_erf_approx_core_test.sv
